>>> sv/rimru_pkg.sv
// package for the recent item mru list: list geometry, field layout of the
// stream words and the sequencer state encoding; no dependencies
package rimru_pkg;

  localparam int LIST_DEPTH = 10;
  localparam int ID_W       = 10;

  // list position and fill count widths
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  // fixed field widths of the stream words
  localparam int ITEM_ID_W   = 10;
  localparam int READ_IDX_W  = 4;
  localparam int VALUE_W     = 10;
  localparam int ENT_CNT_W   = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // compare width for read index against count
  localparam int CMP_W = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_SCAN_RD   = 9'b000000010,
    ST_SCAN_CMP  = 9'b000000100,
    ST_SHIFT_RD  = 9'b000001000,
    ST_SHIFT_WR  = 9'b000010000,
    ST_FRONT     = 9'b000100000,
    ST_READ_RD   = 9'b001000000,
    ST_READ_WAIT = 9'b010000000,
    ST_DONE      = 9'b100000000
  } state_t;

endpackage

>>> sv/rimru_ram.sv
// generic single-write, single-read ram with registered read data
// standalone, no package dependency
module rimru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/recent_item_mru_list_unit.sv
// top level of the recent item mru list: move-to-front list of identifiers
// depends on rimru_pkg and rimru_ram
//
// usage:
//   input stream in_*: in_tuser selects the operation (0 touch, 1 read),
//   in_tdata carries item_id and read_index. one transfer in gives exactly
//   one transfer out on out_*, carrying read_value, entry_valid, hit and
//   the entry count after the item.
//   the list lives in a small ram with one write and one registered read
//   port; a sequencer walks it with a single comparator, reading then
//   comparing each entry on the search and reading then writing each entry
//   moved down on the shift. a read at or past the count skips the ram.
//   a touch hitting at position k searches k+1 entries and moves k down;
//   a touch missing with count c searches c and moves min(c, depth-1)
//   (a touch on an empty list skips search and shift).
//   in_tready is high only while the sequencer is idle; one item is in
//   work at a time, and a new item may be taken while the previous result
//   still sits in the output register.
//   if the receiver stalls, the finished result waits in the sequencer
//   until the output register frees up.
//   reset empties the list (count zero) and drops any pending result; the
//   ram contents need no clearing since only entries below count are used.
module recent_item_mru_list_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rimru_pkg::IN_DATA_W-1:0]   in_tdata,   // item_id[9:0], read_index[13:10]
  input  logic                              in_tuser,   // operation[0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rimru_pkg::OUT_DATA_W-1:0]  out_tdata   // read_value[9:0], entry_valid[10],
                                                        // hit[11], entry_count[15:12]
);

  localparam int AW = rimru_pkg::ADDR_W;
  localparam int CW = rimru_pkg::CNT_W;
  localparam int IW = rimru_pkg::ID_W;

  rimru_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                     count_r, count_nxt;
  logic [AW-1:0]                     ptr_r, ptr_nxt;
  logic [AW-1:0]                     top_r, top_nxt;
  logic [IW-1:0]                     id_r, id_nxt;
  logic [rimru_pkg::READ_IDX_W-1:0]  idx_r, idx_nxt;
  logic                              hit_r, hit_nxt;
  logic                              res_valid_r, res_valid_nxt;
  logic [rimru_pkg::VALUE_W-1:0]     res_value_r, res_value_nxt;
  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [rimru_pkg::OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [IW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [IW-1:0] ram_rdata;

  logic in_xfer;

  rimru_ram #(
    .WIDTH (IW),
    .DEPTH (rimru_pkg::LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == rimru_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    top_nxt        = top_r;
    id_nxt         = id_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    res_valid_nxt  = res_valid_r;
    res_value_nxt  = res_value_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = id_r;
    ram_raddr      = '0;

    case (state_r)
      rimru_pkg::ST_IDLE: begin
        if (in_xfer) begin
          id_nxt        = IW'(in_tdata[rimru_pkg::ITEM_ID_W-1:0]);
          idx_nxt       = in_tdata[rimru_pkg::ITEM_ID_W +: rimru_pkg::READ_IDX_W];
          hit_nxt       = 1'b0;
          res_valid_nxt = 1'b0;
          res_value_nxt = '0;
          ptr_nxt       = '0;
          top_nxt       = '0;
          if (in_tuser == rimru_pkg::OP_READ) begin
            state_nxt = rimru_pkg::ST_READ_RD;
          end else if (count_r == '0) begin
            state_nxt = rimru_pkg::ST_FRONT;
          end else begin
            state_nxt = rimru_pkg::ST_SCAN_RD;
          end
        end
      end
      rimru_pkg::ST_SCAN_RD: begin
        ram_raddr = ptr_r;
        state_nxt = rimru_pkg::ST_SCAN_CMP;
      end
      rimru_pkg::ST_SCAN_CMP: begin
        if (ram_rdata == id_r) begin
          hit_nxt   = 1'b1;
          top_nxt   = ptr_r;
          state_nxt = rimru_pkg::ST_SHIFT_RD;
        end else if ((CW'(ptr_r) + CW'(1)) == count_r) begin
          // miss: on a full list the last entry falls off
          if (count_r < CW'(rimru_pkg::LIST_DEPTH)) begin
            top_nxt = AW'(count_r);
          end else begin
            top_nxt = AW'(rimru_pkg::LIST_DEPTH - 1);
          end
          state_nxt = rimru_pkg::ST_SHIFT_RD;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = rimru_pkg::ST_SCAN_RD;
        end
      end
      rimru_pkg::ST_SHIFT_RD: begin
        if (top_r == '0) begin
          state_nxt = rimru_pkg::ST_FRONT;
        end else begin
          ram_raddr = top_r - AW'(1);
          state_nxt = rimru_pkg::ST_SHIFT_WR;
        end
      end
      rimru_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = top_r;
        ram_wdata = ram_rdata;
        top_nxt   = top_r - AW'(1);
        state_nxt = rimru_pkg::ST_SHIFT_RD;
      end
      rimru_pkg::ST_FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = id_r;
        if (!hit_r && (count_r < CW'(rimru_pkg::LIST_DEPTH))) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = rimru_pkg::ST_DONE;
      end
      rimru_pkg::ST_READ_RD: begin
        if (rimru_pkg::CMP_W'(idx_r) < rimru_pkg::CMP_W'(count_r)) begin
          ram_raddr = AW'(idx_r);
          state_nxt = rimru_pkg::ST_READ_WAIT;
        end else begin
          state_nxt = rimru_pkg::ST_DONE;
        end
      end
      rimru_pkg::ST_READ_WAIT: begin
        res_valid_nxt = 1'b1;
        res_value_nxt = rimru_pkg::VALUE_W'(ram_rdata);
        state_nxt     = rimru_pkg::ST_DONE;
      end
      rimru_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {rimru_pkg::ENT_CNT_W'(count_r), hit_r, res_valid_r, res_value_r};
          state_nxt      = rimru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rimru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rimru_pkg::ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    top_r       <= top_nxt;
    id_r        <= id_nxt;
    idx_r       <= idx_nxt;
    hit_r       <= hit_nxt;
    res_valid_r <= res_valid_nxt;
    res_value_r <= res_value_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

>>> test/tb_top.sv
// testbench for recent_item_mru_list_unit: directed and random touch/read traffic
// checked against a move-to-front list predictor kept inside the bench
// depends on rimru_pkg and the rtl of recent_item_mru_list_unit
module tb_top;
  import rimru_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int ID_POOL_SIZE   = 16;

  typedef struct packed {
    logic                  op;
    logic [ITEM_ID_W-1:0]  item_id;
    logic [READ_IDX_W-1:0] read_index;
  } mru_req_t;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [ENT_CNT_W-1:0] entry_count;
    logic                 hit;
    logic                 entry_valid;
    logic [VALUE_W-1:0]   read_value;
  } mru_rsp_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  recent_item_mru_list_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  mru_req_t        pending_ops[$];
  mru_rsp_t        expected_rsp[$];
  logic [ID_W-1:0] list_ids[LIST_DEPTH];
  int              list_cnt = 0;
  logic [ID_W-1:0] id_pool[ID_POOL_SIZE];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_reqs      = 0;
  int  hold_taken     = 0;
  int  hold_cnt       = 0;
  bit  in_taken       = 1'b0;
  int  idle_cycles    = 0;
  int  fail_cnt       = 0;
  int  n_touch        = 0;
  int  n_hit          = 0;
  int  n_full_miss    = 0;
  int  n_read         = 0;
  int  n_read_valid   = 0;
  int  n_checked      = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // applies one item to the list copy and returns the result it should give
  function automatic mru_rsp_t mru_predict(mru_req_t rq);
    mru_rsp_t        rs;
    int              top;
    logic [ID_W-1:0] id;
    rs = '0;
    id = rq.item_id[ID_W-1:0];
    if (rq.op == OP_TOUCH) begin
      n_touch++;
      top = (list_cnt < LIST_DEPTH) ? list_cnt : LIST_DEPTH - 1;
      for (int k = 0; k < list_cnt; k++) begin
        if (!rs.hit && list_ids[k] == id) begin
          rs.hit = 1'b1;
          top = k;
        end
      end
      for (int k = top; k > 0; k--) list_ids[k] = list_ids[k-1];
      list_ids[0] = id;
      if (rs.hit) begin
        n_hit++;
      end else if (list_cnt < LIST_DEPTH) begin
        list_cnt++;
      end else begin
        n_full_miss++;
      end
    end else begin
      n_read++;
      if (int'(rq.read_index) < list_cnt) begin
        rs.entry_valid = 1'b1;
        rs.read_value  = VALUE_W'(list_ids[rq.read_index]);
        n_read_valid++;
      end
    end
    rs.entry_count = ENT_CNT_W'(list_cnt);
    return rs;
  endfunction

  function automatic mru_req_t random_op();
    mru_req_t rq;
    int       pick;
    rq.op         = OP_TOUCH;
    rq.item_id    = ITEM_ID_W'($urandom_range(0, 1023));
    rq.read_index = READ_IDX_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    // pool ids give frequent hits, fresh ids keep the list turning over
    if (pick < 45) begin
      rq.item_id = ITEM_ID_W'(id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]);
    end else if (pick >= 65) begin
      rq.op = OP_READ;
      if ($urandom_range(0, 3) != 0) rq.read_index = READ_IDX_W'($urandom_range(0, LIST_DEPTH - 1));
    end
    return rq;
  endfunction

  task automatic queue_op(logic op, int id, int idx);
    mru_req_t rq;
    rq.op         = op;
    rq.item_id    = ITEM_ID_W'(id);
    rq.read_index = READ_IDX_W'(idx);
    pending_ops.push_back(rq);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_tvalid || expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, int send_pct, int recv_pct, bit long_hold);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_reqs++;
    for (int n = 0; n < n_items; n++) pending_ops.push_back(random_op());
    wait_drained();
  endtask

  // driver
  always @(negedge clk) begin
    mru_req_t rq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_taken || !in_tvalid) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rq = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= rq.op;
        in_tdata  <= {{(IN_DATA_W - ITEM_ID_W - READ_IDX_W){1'b0}}, rq.read_index, rq.item_id};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with the long hold-off counted here
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt   = hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_cnt   = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    mru_req_t rq;
    mru_rsp_t got;
    mru_rsp_t want;
    bit       out_taken;
    in_taken  = rst_n && in_tvalid && in_tready;
    out_taken = rst_n && out_tvalid && out_tready;
    if (in_taken) begin
      rq.op         = in_tuser;
      rq.item_id    = in_tdata[ITEM_ID_W-1:0];
      rq.read_index = in_tdata[ITEM_ID_W +: READ_IDX_W];
      expected_rsp.push_back(mru_predict(rq));
    end
    if (out_taken) begin
      got = mru_rsp_t'(out_tdata);
      if (expected_rsp.size() == 0) begin
        report_mismatch("transfer with nothing pending, entry_count", got.entry_count, -1);
      end else begin
        want = expected_rsp.pop_front();
        n_checked++;
        if (got.read_value != want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
        if (got.entry_valid != want.entry_valid)
          report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
        if (got.hit != want.hit)
          report_mismatch("hit", got.hit, want.hit);
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
      end
    end
    if (in_taken || out_taken || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_rsp.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < ID_POOL_SIZE; k++) id_pool[k] = ID_W'($urandom_range(0, 1023));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reads on the empty list, then first touch and a hit at the front
    queue_op(OP_READ, 0, 0);
    queue_op(OP_READ, 1023, 15);
    queue_op(OP_TOUCH, 0, 15);
    queue_op(OP_TOUCH, 0, 0);
    queue_op(OP_TOUCH, 1023, 5);
    queue_op(OP_READ, 0, 0);
    queue_op(OP_READ, 0, 1);
    // fill to full depth
    for (int k = 1; k <= 8; k++) queue_op(OP_TOUCH, k, k);
    queue_op(OP_READ, 0, LIST_DEPTH - 1);
    queue_op(OP_READ, 0, LIST_DEPTH);
    // hit at the last position, hit in the middle, miss on a full list
    queue_op(OP_TOUCH, 0, 0);
    queue_op(OP_TOUCH, 5, 0);
    queue_op(OP_TOUCH, 512, 0);
    queue_op(OP_READ, 0, 0);
    queue_op(OP_READ, 0, LIST_DEPTH - 1);
    queue_op(OP_READ, 0, 15);
    queue_op(OP_READ, 1023, 8);
    run_phase(0, 0, 0, 1'b0);

    run_phase(100, 0, 0, 1'b1);
    run_phase(80, 80, 0, 1'b0);
    run_phase(80, 0, 80, 1'b0);
    run_phase(100, 9, 9, 1'b1);
    run_phase(40, 0, 0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d touches (%0d hits, %0d evictions from a full list), %0d reads (%0d valid)",
             n_touch, n_hit, n_full_miss, n_read, n_read_valid);
    $display("%0d results checked under sender gaps, receiver stalls and long hold-offs",
             n_checked);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rimru_pkg.sv
sv/rimru_ram.sv
sv/recent_item_mru_list_unit.sv
test/tb_top.sv
